[design/four_level_error_diffusion_dither_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four-level error diffusion dither
// Shared property forms; each user module supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define FOUR_LEVEL_ERROR_DIFFUSION_DITHER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge
`define FLDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must follow
`define FLDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fldd_pkg.sv]
// ----------------------------------------------------------------------------
// fldd_pkg
// Types and fixed constants shared by the dither front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package fldd_pkg;

  // Input pixel and result payloads
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fldd_pix_in_t;

  typedef struct packed {
    logic [1:0] level;
    logic [7:0] quant_value;
    logic [9:0] column;
    logic [9:0] line;
    logic       frame_end;
  } fldd_pix_out_t;

  // Position flags from the classifier
  typedef struct packed {
    logic last_col;
    logic last_row;
  } fldd_flags_t;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 11'd1024;

  // Datapath widths
  localparam int GRAY_W  = 8;
  localparam int ERR_W   = 6;   // remainder below one level step
  localparam int ADD_W   = 6;   // pending add per column, at most 33
  localparam int PEND_W  = 5;   // diagonal plus five sixteenths, at most 22
  localparam int RIGHT_W = 5;   // seven sixteenths, at most 27
  localparam int DIAG_W  = 2;   // one sixteenth, at most 3

  // Divide by three: x*683 >> 11 is exact for x below 2048
  localparam int               SUM_W      = 10;
  localparam int               PROD_W     = 21;
  localparam logic [PROD_W-1:0] GRAY_RECIP = 21'd683;
  localparam int               GRAY_SHIFT = 11;

  // Queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

endpackage

`default_nettype wire

[design/fldd_front.sv]
// ----------------------------------------------------------------------------
// fldd_front
// Accept pixels, reduce them to gray and tag each with its position.
// ----------------------------------------------------------------------------
`default_nettype none

module fldd_front
  import fldd_pkg::*;
#(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024,
  localparam int CW = $clog2(COL_LIMIT),
  localparam int RW = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire fldd_pix_in_t          in_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output logic [GRAY_W-1:0]          item_gray,
  output logic [CW-1:0]              item_col,
  output logic [RW-1:0]              item_row,
  output fldd_flags_t                item_flags
);

  localparam int CWP = CW + 1;
  localparam int RWP = RW + 1;

  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         col_nxt;
  logic [RW-1:0]         row_r;
  logic [RW-1:0]         row_nxt;
  logic [CWP-1:0]        w_eff;
  logic [RWP-1:0]        h_eff;
  logic [SUM_W-1:0]      rgb_sum;
  logic [PROD_W-1:0]     gray_prod;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp frame size to one through the store limits
  always_comb begin
    if (width_r == '0) begin
      w_eff = CWP'(1);
    end else if (32'(width_r) > COL_LIMIT) begin
      w_eff = CWP'(COL_LIMIT);
    end else begin
      w_eff = CWP'(width_r);
    end
    if (height_r == '0) begin
      h_eff = RWP'(1);
    end else if (32'(height_r) > ROW_LIMIT) begin
      h_eff = RWP'(ROW_LIMIT);
    end else begin
      h_eff = RWP'(height_r);
    end
  end

  // Classify position
  assign last_col = (CWP'(col_r) + CWP'(1)) >= w_eff;
  assign last_row = (RWP'(row_r) + RWP'(1)) >= h_eff;

  // Gray value by reciprocal multiply
  assign rgb_sum   = SUM_W'(in_data.red) + SUM_W'(in_data.green) + SUM_W'(in_data.blue);
  assign gray_prod = PROD_W'(rgb_sum) * GRAY_RECIP;

  assign accept     = in_valid && item_ready;
  assign in_ready   = item_ready;
  assign item_valid = in_valid;
  assign item_gray  = gray_prod[GRAY_SHIFT +: GRAY_W];
  assign item_col   = col_r;
  assign item_row   = row_r;
  assign item_flags = '{last_col: last_col, last_row: last_row};

  // Advance raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`include "four_level_error_diffusion_dither_assert.svh"

  `FLDD_ASSERT_NXT(a_col_wrap, accept && last_col, col_r == '0, "column did not wrap at row end")

endmodule

`default_nettype wire

[design/fldd_queue.sv]
// ----------------------------------------------------------------------------
// fldd_queue
// Two-entry queue that decouples the classifier from the diffusion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fldd_queue
  import fldd_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [DW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output logic [DW-1:0]      pop_data
);

  logic [DW-1:0]     slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // Hold entry payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/fldd_back.sv]
// ----------------------------------------------------------------------------
// fldd_back
// Apply pending diffusion, quantize, spread the error and register results.
// ----------------------------------------------------------------------------
`default_nettype none

module fldd_back
  import fldd_pkg::*;
#(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024,
  localparam int CW = $clog2(COL_LIMIT),
  localparam int RW = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  output logic              q_ready,
  input  wire logic [GRAY_W-1:0] q_gray,
  input  wire logic [CW-1:0] q_col,
  input  wire logic [RW-1:0] q_row,
  input  wire fldd_flags_t  q_flags,
  output logic              out_valid,
  input  wire logic         out_ready,
  output fldd_pix_out_t     out_data
);

  localparam int CWP = CW + 1;
  localparam int VAL_W = 9;

  // Line store of next-row adds
  logic [ADD_W-1:0]  line_store_r [COL_LIMIT];
  logic [ADD_W-1:0]  rd_r;

  // Compute stage
  logic              b2_v_r;
  logic [GRAY_W-1:0] b2_gray_r;
  logic [CW-1:0]     b2_col_r;
  logic [RW-1:0]     b2_row_r;
  fldd_flags_t       b2_flags_r;
  logic              fwd_hit_r;
  logic [ADD_W-1:0]  fwd_data_r;
  logic              in_range_r;

  // Diffusion state
  logic [RIGHT_W-1:0] right_r;
  logic [DIAG_W-1:0]  diag_r;
  logic [PEND_W-1:0]  pend_r;
  logic               tail_v_r;
  logic [CW-1:0]      tail_addr_r;
  logic [ADD_W-1:0]   tail_data_r;
  logic [CWP-1:0]     hw_r;
  logic [CWP-1:0]     hw_nxt;

  // Output register
  logic               out_v_r;
  fldd_pix_out_t      out_data_r;

  logic               out_free;
  logic               wr_want;
  logic               fire;
  logic               load;
  logic               frame_end;
  logic               fire_wr;
  logic               tail_set;
  logic [ADD_W-1:0]   below;
  logic [VAL_W-1:0]   val_sum;
  logic [GRAY_W-1:0]  val;
  logic [1:0]         lvl;
  logic [ERR_W-1:0]   err;
  logic [8:0]         err7;
  logic [8:0]         err5;
  logic [7:0]         err3;
  logic [PEND_W-1:0]  pend_new;
  logic [ADD_W-1:0]   fin;
  logic               mem_we;
  logic [CW-1:0]      mem_wa;
  logic [ADD_W-1:0]   mem_wd;

  // Handshake between queue, compute stage and output register
  assign out_free  = !out_v_r || out_ready;
  assign wr_want   = !frame_end && (b2_col_r != '0 || b2_flags_r.last_col);
  // Hold back a one-column row item while a deferred write holds the port
  assign fire      = b2_v_r && out_free && !(tail_v_r && wr_want);
  assign q_ready   = !b2_v_r || fire;
  assign load      = q_valid && q_ready;
  assign frame_end = b2_flags_r.last_col && b2_flags_r.last_row;

  // Pending add for this pixel, forwarded or masked beyond the written prefix
  assign below = fwd_hit_r ? fwd_data_r : (in_range_r ? rd_r : '0);

  // Quantize with one saturation
  assign val_sum = VAL_W'(b2_gray_r) + VAL_W'(below) + VAL_W'(right_r);
  assign val     = val_sum[8] ? 8'd255 : val_sum[7:0];
  assign lvl     = val[7:6];
  assign err     = val[ERR_W-1:0];

  // Error shares
  assign err7     = 9'(err) * 9'd7;
  assign err5     = 9'(err) * 9'd5;
  assign err3     = 8'(err) * 8'd3;
  assign pend_new = PEND_W'(diag_r) + PEND_W'(err5[8:4]);
  assign fin      = ADD_W'(pend_r) + ADD_W'(err3[7:4]);

  assign fire_wr  = fire && wr_want;
  assign tail_set = fire && !frame_end && b2_flags_r.last_col && b2_col_r != '0;

  // Single write port: deferred row-end entry, left neighbor, or lone column
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    priority if (tail_v_r) begin
      mem_we = 1'b1;
      mem_wa = tail_addr_r;
      mem_wd = tail_data_r;
    end else if (fire && !frame_end && b2_col_r != '0) begin
      mem_we = 1'b1;
      mem_wa = b2_col_r - CW'(1);
      mem_wd = fin;
    end else if (fire && !frame_end && b2_flags_r.last_col) begin
      mem_we = 1'b1;
      mem_wa = b2_col_r;
      mem_wd = ADD_W'(pend_new);
    end
  end

  // Written-prefix mark; drop the whole store at frame end
  always_comb begin
    hw_nxt = hw_r;
    priority if (fire && frame_end) begin
      hw_nxt = '0;
    end else if (mem_we && CWP'(mem_wa) >= hw_r) begin
      hw_nxt = CWP'(mem_wa) + CWP'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store_r[mem_wa] <= mem_wd;
    end
    if (load) begin
      rd_r <= line_store_r[q_col];
    end
  end

  // Compute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (load) begin
      b2_v_r <= 1'b1;
    end else if (fire) begin
      b2_v_r <= 1'b0;
    end
  end

  // Capture item and same-edge write for forwarding
  always_ff @(posedge clk) begin
    if (load) begin
      b2_gray_r  <= q_gray;
      b2_col_r   <= q_col;
      b2_row_r   <= q_row;
      b2_flags_r <= q_flags;
      fwd_hit_r  <= mem_we && (mem_wa == q_col);
      fwd_data_r <= mem_wd;
      in_range_r <= CWP'(q_col) < hw_nxt;
    end
  end

  // Advance diffusion state on each transfer out of the compute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r  <= '0;
      diag_r   <= '0;
      pend_r   <= '0;
      tail_v_r <= 1'b0;
      hw_r     <= '0;
    end else begin
      hw_r     <= hw_nxt;
      tail_v_r <= tail_set;
      if (fire) begin
        pend_r  <= pend_new;
        right_r <= b2_flags_r.last_col ? '0 : err7[8:4];
        diag_r  <= b2_flags_r.last_col ? '0 : err[5:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_set) begin
      tail_addr_r <= b2_col_r;
      tail_data_r <= ADD_W'(pend_new);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.level       <= lvl;
      out_data_r.quant_value <= {lvl, 6'b0};
      out_data_r.column      <= 10'(b2_col_r);
      out_data_r.line        <= 10'(b2_row_r);
      out_data_r.frame_end   <= frame_end;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

`include "four_level_error_diffusion_dither_assert.svh"

  `FLDD_ASSERT_IMP(a_port_clash, tail_v_r, !fire_wr, "deferred write collides with store write")
  `FLDD_ASSERT_NXT(a_frame_clear, fire && frame_end, hw_r == '0, "store not dropped at frame end")
  `FLDD_ASSERT_NXT(a_row_clear, fire && b2_flags_r.last_col,
                   right_r == '0 && diag_r == '0, "row carries not cleared at row end")

endmodule

`default_nettype wire

[design/four_level_error_diffusion_dither.sv]
// Path: an input is queued, loaded into the compute stage, then registered at the output.
// Throughput: one pixel per cycle when not stalled; one-column rows after a row end wait.
// The right-neighbor error feeds back within the single compute stage on each transfer.
// Reset (synchronous, active low): position, carries, queue and output cleared;
// width and height return to 1024; the line store is dropped by a written-prefix mark,
// so no clearing pass is needed and pixels are taken right after reset.
// ----------------------------------------------------------------------------
// four_level_error_diffusion_dither
// Streaming four-level error diffusion of RGB pixels in raster order.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_error_diffusion_dither
  import fldd_pkg::*;
#(
  parameter int COL_LIMIT = 1024,
  parameter int ROW_LIMIT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire fldd_pix_in_t          in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output fldd_pix_out_t              out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(COL_LIMIT);
  localparam int RW = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
  localparam int FW = $bits(fldd_flags_t);
  localparam int QW = GRAY_W + CW + RW + FW;

  logic              f_valid;
  logic              f_ready;
  logic [GRAY_W-1:0] f_gray;
  logic [CW-1:0]     f_col;
  logic [RW-1:0]     f_row;
  fldd_flags_t       f_flags;
  logic              q_valid;
  logic              q_ready;
  logic [QW-1:0]     q_data;
  fldd_flags_t       q_flags;

  // Classify incoming pixels
  fldd_front #(
    .COL_LIMIT (COL_LIMIT),
    .ROW_LIMIT (ROW_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_gray  (f_gray),
    .item_col   (f_col),
    .item_row   (f_row),
    .item_flags (f_flags)
  );

  // Decouple front and back
  fldd_queue #(
    .DW (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_gray, f_col, f_row, f_flags}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_flags = q_data[FW-1:0];

  // Diffuse and deliver
  fldd_back #(
    .COL_LIMIT (COL_LIMIT),
    .ROW_LIMIT (ROW_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_gray    (q_data[QW-1 -: GRAY_W]),
    .q_col     (q_data[FW+RW +: CW]),
    .q_row     (q_data[FW +: RW]),
    .q_flags   (q_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_four_level_error_diffusion_dither.sv]
// ----------------------------------------------------------------------------
// tb_four_level_error_diffusion_dither
// Drives RGB pixels through the dither with random idling on both channels and
// rewrites the frame size between phases. Each transfer is predicted by a
// local model of the error diffusion and each result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_level_error_diffusion_dither;
  import fldd_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 1024;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES  = 10;
  localparam int LONG_HOLD   = 80;

  typedef enum bit {STIM_PIXEL, STIM_WRITE} stim_kind_t;
  typedef enum bit [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic          pinned;
    fldd_pix_out_t value;
  } pin_t;

  typedef struct packed {
    stim_kind_t             kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    fldd_pix_in_t           pixel;
    pin_t                   pin;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  fldd_pix_in_t          in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  fldd_pix_out_t         out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  four_level_error_diffusion_dither dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: pending adds for the next row and the running position
  logic [7:0]            line_adds [MAX_W];
  int unsigned           right_carry;
  int unsigned           diag_share;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  fldd_pix_out_t expected_pixels [$];
  pin_t          pinned_pixels [$];
  stim_row_t     directed_rows [$];

  idle_mode_t idle_mode = IDLE_NONE;
  int         recv_hold = 0;
  int         mismatches = 0;
  int         results_checked = 0;
  int         frames_done = 0;
  int         pixels_sent = 0;
  int         cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clip255(input int unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  // Dither one pixel and advance the predictor state
  function automatic fldd_pix_out_t dither_pixel(input fldd_pix_in_t px);
    int unsigned   w, h, c, r, gray, val, err;
    bit            lc, lr;
    fldd_pix_out_t res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    r = row_pos;
    lc = (c + 1 >= w);
    lr = (r + 1 >= h);
    gray = (32'(px.red) + 32'(px.green) + 32'(px.blue)) / 3;
    val = clip255(gray + 32'(line_adds[c]) + right_carry);
    err = val & 63;
    res.level       = 2'(val >> 6);
    res.quant_value = 8'((val >> 6) * 64);
    res.column      = 10'(c);
    res.line        = 10'(r);
    res.frame_end   = lc && lr;
    // spread the remainder: down-left, down (plus diagonal carry), right
    if (c > 0) line_adds[c-1] = 8'(clip255(32'(line_adds[c-1]) + (3 * err) / 16));
    line_adds[c] = 8'(clip255(diag_share + (5 * err) / 16));
    diag_share  = lc ? 0 : err / 16;
    right_carry = lc ? 0 : (7 * err) / 16;
    if (!lc) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      if (lr) begin
        row_pos = 0;
        foreach (line_adds[i]) line_adds[i] = '0;
      end else begin
        row_pos = r + 1;
      end
    end
    return res;
  endfunction

  function automatic fldd_pix_in_t rgb(input int r, input int g, input int b);
    fldd_pix_in_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  function automatic fldd_pix_out_t outcome(input int lvl, input int q, input int col,
                                            input int ln, input bit fe);
    fldd_pix_out_t res;
    res.level       = 2'(lvl);
    res.quant_value = 8'(q);
    res.column      = 10'(col);
    res.line        = 10'(ln);
    res.frame_end   = fe;
    return res;
  endfunction

  function automatic stim_row_t pixel_row(input int r, input int g, input int b);
    stim_row_t row;
    row = '0;
    row.kind  = STIM_PIXEL;
    row.pixel = rgb(r, g, b);
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input int r, input int g, input int b,
                                           input fldd_pix_out_t want);
    stim_row_t row;
    row = pixel_row(r, g, b);
    row.pin.pinned = 1'b1;
    row.pin.value  = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    stim_row_t row;
    row = '0;
    row.kind      = STIM_WRITE;
    row.reg_index = idx;
    row.reg_value = CFG_DATA_W'(val);
    return row;
  endfunction

  // Mix of uniform bytes, channel extremes, level edges, dark and bright
  function automatic fldd_pix_in_t random_pixel();
    int v;
    case ($urandom_range(0, 4))
      0: return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      1: return rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255);
      2: begin
        v = 64 * $urandom_range(1, 3) - $urandom_range(0, 1);
        return rgb(v, v, v + $urandom_range(0, 1));
      end
      3: return rgb($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20));
      default: return rgb($urandom_range(230, 255), $urandom_range(230, 255),
                          $urandom_range(230, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH: %s", what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                results_checked, name, got, want));
  endtask

  // Offer one pixel, with random gaps ahead of it, and hold until transfer
  task automatic send_pixel(input fldd_pix_in_t px, input pin_t pin);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 57 : (idle_mode == IDLE_BOTH) ? 18 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_pixels.push_back(pin);
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pinned_pixels.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: long hold when requested, otherwise stall by idle mode
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold = recv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >=
                    ((idle_mode == IDLE_RECV) ? 57 : (idle_mode == IDLE_BOTH) ? 18 : 0));
    end
  end

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin : scoreboard
    pin_t          pin;
    fldd_pix_out_t predicted;
    fldd_pix_out_t want;
    if (!rst_n) begin
      foreach (line_adds[i]) line_adds[i] = '0;
      right_carry = 0;
      diag_share  = 0;
      col_pos     = 0;
      row_pos     = 0;
      width_reg   = DIM_RESET;
      height_reg  = DIM_RESET;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata;
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        pin = pinned_pixels.pop_front();
        predicted = dither_pixel(in_data);
        expected_pixels.push_back(pin.pinned ? pin.value : predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending",
                                    results_checked));
        end else begin
          want = expected_pixels.pop_front();
          check_field("level", out_data.level, want.level);
          check_field("quant_value", out_data.quant_value, want.quant_value);
          check_field("column", out_data.column, want.column);
          check_field("line", out_data.line, want.line);
          check_field("frame_end", out_data.frame_end, want.frame_end);
        end
        if (out_data.frame_end) frames_done++;
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        w, h, items;
    bit        write_w, write_h;

    // Directed table: pinned rows follow directly from reset or a 1x1 frame
    directed_rows.push_back(pinned_row(255, 255, 255, outcome(3, 192, 0, 0, 0)));
    directed_rows.push_back(pinned_row(0, 0, 0, outcome(0, 0, 1, 0, 0)));
    directed_rows.push_back(pixel_row(1, 2, 3));
    // shrink mid-frame: position past the new last column ends the frame
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 1));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 1));
    directed_rows.push_back(pixel_row(128, 128, 128));
    directed_rows.push_back(pinned_row(255, 255, 255, outcome(3, 192, 0, 0, 1)));
    directed_rows.push_back(pinned_row(0, 0, 0, outcome(0, 0, 0, 0, 1)));
    directed_rows.push_back(pinned_row(64, 64, 64, outcome(1, 64, 0, 0, 1)));
    directed_rows.push_back(pinned_row(63, 64, 64, outcome(0, 0, 0, 0, 1)));
    directed_rows.push_back(pinned_row(255, 0, 0, outcome(1, 64, 0, 0, 1)));
    directed_rows.push_back(pinned_row(128, 128, 129, outcome(2, 128, 0, 0, 1)));
    // zero size reads as one
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 0));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 0));
    directed_rows.push_back(pinned_row(192, 192, 192, outcome(3, 192, 0, 0, 1)));
    // oversize saturates to the limit
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 2047));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 2047));
    directed_rows.push_back(pinned_row(255, 255, 255, outcome(3, 192, 0, 0, 0)));
    directed_rows.push_back(pixel_row(255, 255, 255));
    // small frame of bright and dark pixels, saturating adds
    directed_rows.push_back(write_row(REG_IMAGE_WIDTH, 3));
    directed_rows.push_back(write_row(REG_IMAGE_HEIGHT, 2));
    directed_rows.push_back(pixel_row(255, 255, 255));
    directed_rows.push_back(pixel_row(255, 255, 254));
    directed_rows.push_back(pixel_row(250, 255, 255));
    directed_rows.push_back(pixel_row(255, 255, 255));
    directed_rows.push_back(pixel_row(0, 0, 0));
    directed_rows.push_back(pixel_row(63, 63, 63));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == STIM_WRITE) write_reg(row.reg_index, row.reg_value);
      else send_pixel(row.pixel, row.pin);
    end

    // Random phases: new frame size while idle, then a run of pixels
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_w = 1'b1;
      write_h = 1'b1;
      items   = 60;
      case (ph)
        0: begin w = 1024; h = 2; items = 1050; end
        1: begin w = 1; h = 1024; items = 250; end
        2: begin write_w = 1'b0; h = 3; end
        3: begin write_h = 1'b0; w = 7; end
        default: begin
          case ($urandom_range(0, 9))
            0: w = 0;
            1: w = $urandom_range(1025, 2047);
            default: w = $urandom_range(1, 24);
          endcase
          h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
          if (ph > 4) begin
            write_w = ($urandom_range(0, 3) != 0);
            write_h = ($urandom_range(0, 3) != 0);
          end
        end
      endcase
      if (write_w) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      if (write_h) write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      idle_mode = idle_mode_t'(ph % 4);
      // hold the receiver off so the block fills and stalls its input
      if (ph == 1) recv_hold = LONG_HOLD;
      for (int k = 0; k < items; k++) begin
        if (ph == 4 && k == items / 2) wait_drained();
        send_pixel(random_pixel(), '0);
      end
    end

    wait_drained();
    $display("Dithered %0d pixels across %0d phases; %0d results checked, %0d frames ended",
             pixels_sent, NUM_PHASES, results_checked, frames_done);
    $display("Covered zero, full and oversize frame sizes, mid-frame resizing and stalls");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
